// ----- src/tempo_clock_divider_with_swing_unit_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef TEMPO_CLOCK_DIVIDER_WITH_SWING_UNIT_MACROS_SVH
`define TEMPO_CLOCK_DIVIDER_WITH_SWING_UNIT_MACROS_SVH

// Same-cycle implication.
`define TCDWS_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcdws: check failed");

// Next-cycle implication.
`define TCDWS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcdws: check failed");

`endif

// ----- src/tcdws_pkg.sv -----
package tcdws_pkg;

  localparam int SR_W       = 18;
  localparam int OFF_W      = 8;
  localparam int BPM_W      = 8;
  localparam int PW_W       = 8;
  localparam int STEP_W     = 4;
  localparam int TICK_W     = 17;
  localparam int NOTE_W     = 5;
  localparam int SWING_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int FRAC_W     = 8;
  // sample_rate * 15 * 256 fits in 30 bits; quotient by 30 or more fits in 25
  localparam int DIV_NUM_W  = 30;
  localparam int STEP_FX_W  = 25;

  localparam int STEPS_PER_BAR     = 16;
  localparam int SWING_OUTPUTS_DEF = 6;

  localparam logic [BPM_W-1:0] BPM_MIN = 8'd30;
  localparam logic [BPM_W-1:0] BPM_MAX = 8'd200;
  localparam logic [PW_W-1:0]  PW_MIN  = 8'd26;
  localparam logic [PW_W-1:0]  PW_MAX  = 8'd154;

  localparam logic [SR_W-1:0]  SR_RESET  = 18'd44100;
  localparam logic [OFF_W-1:0] OFF_RESET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_LAST  = 3'd6;

  typedef struct packed {
    logic [BPM_W-1:0] tempo_bpm;
    logic [PW_W-1:0]  pulse_width;
    logic             swing_sixteenth;
    logic             reset_level;
    logic             run_cv_present;
    logic             run_cv_level;
    logic             run_button_level;
  } in_t;

  typedef struct packed {
    logic [NOTE_W-1:0]  note_gates;
    logic [SWING_W-1:0] swing_gates;
    logic               is_running;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WMUL,
    ST_GATE,
    ST_SMUL,
    ST_SCMP,
    ST_DONE
  } state_e;

  function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] lo,
                                        input logic [7:0] hi);
    logic [7:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // bit0 whole, bit1 half, bit2 quarter, bit3 eighth, bit4 sixteenth
  function automatic logic [NOTE_W-1:0] note_mask(input logic [STEP_W-1:0] step);
    logic [NOTE_W-1:0] m;
    m = 5'b10000;
    if (step[0] == 1'b0)   m[3] = 1'b1;
    if (step[1:0] == 2'd0) m[2] = 1'b1;
    if (step[2:0] == 3'd0) m[1] = 1'b1;
    if (step == 4'd0)      m[0] = 1'b1;
    return m;
  endfunction

endpackage

// ----- src/tcdws_div.sv -----
module tcdws_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tcdws_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [tcdws_pkg::BPM_W-1:0]      den_i,
  output logic                             done_o,
  output logic [tcdws_pkg::STEP_FX_W-1:0]  quo_o
);
  import tcdws_pkg::*;

  localparam int CntW = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [BPM_W-1:0]     rem_q, rem_d;
  logic [BPM_W-1:0]     den_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [BPM_W:0]       rem_sh;
  logic [BPM_W:0]       rem_sub;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, num_q[DIV_NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_d   = ge ? rem_sub[BPM_W-1:0] : rem_sh[BPM_W-1:0];
    num_d   = {num_q[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q[STEP_FX_W-1:0];

endmodule

// ----- src/tempo_clock_divider_with_swing_unit.sv -----
// Tempo clock divider with swing gates.
// One input word per audio sample tick on in_valid_i/in_ready_o; one result
// word per input word on out_valid_o/out_ready_i. Configuration is a plain
// write port: cfg_idx_i 0 is the sample rate, 1..6 the swing offsets.
// A tick while stopped goes straight to the output register load. A running
// tick passes the bit-serial step-length divider, then the shared 25x8
// multiplier on the gate width, the gate update and the output register load.
// Odd swing steps add an offset multiply and compare per swing gate.
// One word is in work at a time; the input is ready again the cycle after the
// result is loaded into the output register, so a new word is taken only after
// the result of the last one is in the output register.
// Reset: sample rate 44100, offsets 128, run on, counters and gates zero.
// When the receiver stalls, the finished result waits in the output register
// and a new word can be taken; its result waits in the sequencer until the
// output register frees, and the input is not ready meanwhile.
`include "tempo_clock_divider_with_swing_unit_macros.svh"

module tempo_clock_divider_with_swing_unit #(
  parameter int SwingOutputs = tcdws_pkg::SWING_OUTPUTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tcdws_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tcdws_pkg::out_t                   out_data_o,
  input  logic                              cfg_we_i,
  input  logic [tcdws_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcdws_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tcdws_pkg::*;

  // gates past the sixth fall outside the output field
  localparam int NumSwing = (SwingOutputs < SWING_W) ? SwingOutputs : SWING_W;
  localparam int SwIdxW   = (NumSwing > 1) ? $clog2(NumSwing) : 1;
  localparam logic [SWING_W-1:0] SwMask = SWING_W'((1 << NumSwing) - 1);

  state_e state_q, state_d;

  logic [SR_W-1:0]      sr_q;
  logic [OFF_W-1:0]     off_q [NumSwing];
  logic                 run_q;
  logic [2:0]           prev_q;
  logic [STEP_W-1:0]    step_q;
  logic [TICK_W-1:0]    tick_q;
  logic [NOTE_W-1:0]    note_q;
  logic [SWING_W-1:0]   swing_q;
  logic [PW_W-1:0]      pw_q;
  logic                 six_q;
  logic [STEP_FX_W-1:0] step_fx_q;
  logic [STEP_FX_W-1:0] width_q;
  logic [STEP_FX_W-1:0] prod_q;
  logic [SwIdxW-1:0]    sw_idx_q;
  logic                 out_valid_q;
  out_t                 out_q;

  logic                        in_fire;
  logic                        out_free;
  logic                        rise_rst, tog_cv, tog_btn, run_new;
  logic [2:0]                  prev_new;
  logic [DIV_NUM_W-1:0]        div_num;
  logic [BPM_W-1:0]            bpm_clamped;
  logic                        div_done;
  logic [STEP_FX_W-1:0]        div_quo;
  logic [OFF_W-1:0]            mul_op;
  logic [STEP_FX_W+OFF_W-1:0]  mul_full;
  logic [STEP_FX_W-1:0]        mul_res;
  logic [STEP_FX_W-1:0]        tick_fx;
  logic [TICK_W-1:0]           tick_inc;
  logic                        step_end;
  logic                        sw_apply, sw_odd;
  logic                        sw_on;
  logic [SWING_W-1:0]          sw_sel;
  logic [CFG_IDX_W-1:0]        cfg_slot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // edge detection on the level inputs
  always_comb begin
    rise_rst    = in_data_i.reset_level && !prev_q[0];
    prev_new    = prev_q;
    prev_new[0] = in_data_i.reset_level;
    tog_cv      = 1'b0;
    if (in_data_i.run_cv_present) begin
      tog_cv      = in_data_i.run_cv_level && !prev_q[1];
      prev_new[1] = in_data_i.run_cv_level;
    end
    tog_btn     = in_data_i.run_button_level && !prev_q[2];
    prev_new[2] = in_data_i.run_button_level;
    run_new     = (rise_rst | run_q) ^ tog_cv ^ tog_btn;
  end

  assign bpm_clamped = clamp8(in_data_i.tempo_bpm, BPM_MIN, BPM_MAX);
  assign div_num     = {sr_q, 12'b0} - DIV_NUM_W'({sr_q, 8'b0});

  tcdws_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire && run_new),
    .num_i   (div_num),
    .den_i   (bpm_clamped),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // shared multiplier: gate width, then swing offsets
  assign mul_op   = (state_q == ST_WMUL) ? pw_q : off_q[sw_idx_q];
  assign mul_full = step_fx_q * mul_op;
  assign mul_res  = mul_full[STEP_FX_W+FRAC_W-1:FRAC_W];

  assign tick_fx  = {tick_q, 8'b0};
  assign tick_inc = tick_q + 1'b1;
  assign step_end = {tick_inc, 8'b0} >= step_fx_q;
  assign sw_apply = six_q || !step_q[0];
  assign sw_odd   = six_q ? step_q[0] : step_q[1];
  assign sw_on    = (tick_fx >= prod_q) &&
                    ({1'b0, tick_fx} <= ({1'b0, prod_q} + {1'b0, width_q}));
  assign sw_sel   = SWING_W'(1) << sw_idx_q;
  assign cfg_slot = cfg_idx_i - CFG_SWING_FIRST;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = run_new ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done) state_d = ST_WMUL;
      ST_WMUL: state_d = ST_GATE;
      ST_GATE: state_d = (sw_apply && sw_odd) ? ST_SMUL : ST_DONE;
      ST_SMUL: state_d = ST_SCMP;
      ST_SCMP: state_d = (sw_idx_q == SwIdxW'(NumSwing - 1)) ? ST_DONE : ST_SMUL;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= SR_RESET;
      for (int i = 0; i < NumSwing; i++) off_q[i] <= OFF_RESET;
      run_q       <= 1'b1;
      prev_q      <= '0;
      step_q      <= '0;
      tick_q      <= '0;
      note_q      <= '0;
      swing_q     <= '0;
      sw_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SAMPLE_RATE) begin
          sr_q <= cfg_data_i[SR_W-1:0];
        end else if (cfg_idx_i >= CFG_SWING_FIRST && cfg_idx_i <= CFG_SWING_LAST) begin
          if (cfg_slot < CFG_IDX_W'(NumSwing)) off_q[cfg_slot[SwIdxW-1:0]] <= cfg_data_i[OFF_W-1:0];
        end
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            prev_q <= prev_new;
            run_q  <= run_new;
            if (rise_rst) begin
              step_q <= '0;
              tick_q <= '0;
            end
          end
        end
        ST_GATE: begin
          if (tick_q >= width_q[STEP_FX_W-1:FRAC_W]) note_q <= '0;
          else note_q <= note_q | note_mask(step_q);
          if (sw_apply && !sw_odd) begin
            swing_q <= (tick_fx < width_q) ? (swing_q | SwMask) : (swing_q & ~SwMask);
          end
          sw_idx_q <= '0;
        end
        ST_SCMP: begin
          swing_q  <= sw_on ? (swing_q | sw_sel) : (swing_q & ~sw_sel);
          sw_idx_q <= sw_idx_q + 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            if (run_q) begin
              if (step_end) begin
                tick_q <= '0;
                step_q <= (step_q == STEP_W'(STEPS_PER_BAR - 1)) ? '0 : step_q + 1'b1;
              end else begin
                tick_q <= tick_inc;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pw_q  <= clamp8(in_data_i.pulse_width, PW_MIN, PW_MAX);
      six_q <= in_data_i.swing_sixteenth;
    end
    if (state_q == ST_DIV && div_done) step_fx_q <= div_quo;
    if (state_q == ST_WMUL) width_q <= mul_res;
    if (state_q == ST_SMUL) prod_q <= mul_res;
    if (state_q == ST_DONE && out_free) begin
      out_q.note_gates  <= note_q;
      out_q.swing_gates <= swing_q;
      out_q.is_running  <= run_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCDWS_ASSERT(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE)
  `TCDWS_ASSERT_NEXT(a_run_at_accept, !in_fire, $stable(run_q))
  `TCDWS_ASSERT_NEXT(a_step_hold, !in_fire && state_q != ST_DONE, $stable(step_q))
  `TCDWS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o)

endmodule

// ----- tb/tcdws_gate_checker.sv -----
`timescale 1ns / 100ps

module tcdws_gate_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  tcdws_pkg::in_t                   in_data_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  tcdws_pkg::out_t                  out_data_o,
  input  logic                             cfg_we_i,
  input  logic [tcdws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcdws_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                               mismatches,
  output int                               outstanding
);
  import tcdws_pkg::*;

  logic [SR_W-1:0]    rate_hz;
  logic [OFF_W-1:0]   swing_off [SWING_W];
  logic [STEP_W-1:0]  step_q;
  logic [TICK_W-1:0]  tick_q;
  logic               run_q;
  logic [2:0]         lvl_q;
  logic [NOTE_W-1:0]  note_q;
  logic [SWING_W-1:0] swing_q;
  out_t               gate_queue [$];

  task automatic report_mismatch(input string what, input int unsigned exp,
                                 input int unsigned got);
    $display("[%0t] mismatch %s: expected 'h%0h, got 'h%0h", $time, what, exp, got);
    mismatches++;
  endtask

  task automatic predict_gates(input in_t w);
    logic [63:0]       sr64, bpm64, pw64, step_fx, width_fx, tick_fx, off_fx;
    logic [7:0]        bpm, pw;
    logic [2:0]        lv;
    logic [NOTE_W-1:0] nm;
    int unsigned       rate;
    logic              odd, on;
    out_t              r;
    bpm = (w.tempo_bpm < BPM_MIN) ? BPM_MIN : ((w.tempo_bpm > BPM_MAX) ? BPM_MAX : w.tempo_bpm);
    pw  = (w.pulse_width < PW_MIN) ? PW_MIN : ((w.pulse_width > PW_MAX) ? PW_MAX : w.pulse_width);
    lv = lvl_q;
    if (w.reset_level && !lv[0]) begin
      step_q = '0;
      tick_q = '0;
      run_q  = 1'b1;
    end
    lv[0] = w.reset_level;
    // run CV edge memory freezes while the jack is unplugged
    if (w.run_cv_present) begin
      if (w.run_cv_level && !lv[1]) run_q = !run_q;
      lv[1] = w.run_cv_level;
    end
    if (w.run_button_level && !lv[2]) run_q = !run_q;
    lv[2] = w.run_button_level;
    lvl_q = lv;
    if (run_q) begin
      sr64     = rate_hz;
      bpm64    = bpm;
      pw64     = pw;
      step_fx  = (sr64 * 64'd3840) / bpm64;
      width_fx = (step_fx * pw64) >> 8;
      tick_fx  = {47'd0, tick_q} << 8;
      rate     = w.swing_sixteenth ? 1 : 2;
      nm = {1'b1, ~step_q[0], step_q[1:0] == 2'd0, step_q[2:0] == 3'd0, step_q == 4'd0};
      if ({47'd0, tick_q} >= (width_fx >> 8)) note_q = '0;
      else note_q = note_q | nm;
      if ((step_q % rate) == 0) begin
        odd = (step_q % (rate * 2)) != 0;
        for (int i = 0; i < SWING_W; i++) begin
          if (odd) begin
            off_fx = (step_fx * {56'd0, swing_off[i]}) >> 8;
            on = (tick_fx >= off_fx) && (tick_fx <= off_fx + width_fx);
          end else begin
            on = tick_fx < width_fx;
          end
          swing_q[i] = on;
        end
      end
      tick_q = tick_q + 1'b1;
      if (({47'd0, tick_q} << 8) >= step_fx) begin
        tick_q = '0;
        step_q = step_q + 1'b1;
      end
    end
    r.note_gates  = note_q;
    r.swing_gates = swing_q;
    r.is_running  = run_q;
    gate_queue.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      rate_hz = SR_RESET;
      foreach (swing_off[i]) swing_off[i] = OFF_RESET;
      step_q      = '0;
      tick_q      = '0;
      run_q       = 1'b1;
      lvl_q       = '0;
      note_q      = '0;
      swing_q     = '0;
      mismatches  = 0;
      gate_queue.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (gate_queue.size() == 0) begin
          report_mismatch("word with nothing pending", 0, out_data_o);
        end else begin
          exp_w = gate_queue.pop_front();
          if (out_data_o.note_gates !== exp_w.note_gates)
            report_mismatch("note_gates", exp_w.note_gates, out_data_o.note_gates);
          if (out_data_o.swing_gates !== exp_w.swing_gates)
            report_mismatch("swing_gates", exp_w.swing_gates, out_data_o.swing_gates);
          if (out_data_o.is_running !== exp_w.is_running)
            report_mismatch("is_running", exp_w.is_running, out_data_o.is_running);
        end
      end
      if (in_valid_i && in_ready_o) predict_gates(in_data_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SAMPLE_RATE)
          rate_hz = cfg_data_i[SR_W-1:0];
        else if (cfg_idx_i >= CFG_SWING_FIRST && cfg_idx_i <= CFG_SWING_LAST)
          swing_off[cfg_idx_i - CFG_SWING_FIRST] = cfg_data_i[OFF_W-1:0];
      end
    end
    outstanding = gate_queue.size();
  end

endmodule

// ----- tb/tb_tempo_clock_divider_with_swing_unit.sv -----
`timescale 1ns / 100ps

module tb_tempo_clock_divider_with_swing_unit;
  import tcdws_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int IDLE_PCT      = 18;
  localparam int OFFS_RANDOM   = 0;
  localparam int OFFS_EDGE     = 1;
  localparam int OFFS_EDGE_INV = 2;
  localparam int IN_W          = $bits(in_t);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  out_ready_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  in_t                   in_data_i   = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  out_t                  out_data_o;

  int   mismatches;
  int   outstanding;
  int   cycles        = 0;
  int   words_sent    = 0;
  int   settings_used = 0;
  logic quiet         = 1'b0;

  logic [7:0] cur_tempo = 8'd120;
  logic       lvl_rst   = 1'b0;
  logic       lvl_cvp   = 1'b0;
  logic       lvl_cv    = 1'b0;
  logic       lvl_btn   = 1'b0;

  tempo_clock_divider_with_swing_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  tcdws_gate_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, outstanding);
      $display("** tempo_clock_divider_with_swing_unit: FAILED **");
      $finish;
    end
  end

  function automatic in_t mk_word(input logic [7:0] tempo, input logic [7:0] pw,
                                  input logic six, input logic rst, input logic cvp,
                                  input logic cv, input logic btn);
    in_t w;
    w.tempo_bpm        = tempo;
    w.pulse_width      = pw;
    w.swing_sixteenth  = six;
    w.reset_level      = rst;
    w.run_cv_present   = cvp;
    w.run_cv_level     = cv;
    w.run_button_level = btn;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_t w);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic load_setting(input logic [SR_W-1:0] sr, input int kind);
    logic [OFF_W-1:0] off;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    write_reg(CFG_SAMPLE_RATE, sr);
    for (int i = 0; i < SWING_W; i++) begin
      case (kind)
        OFFS_EDGE:     off = i[0] ? 8'd255 : 8'd0;
        OFFS_EDGE_INV: off = i[0] ? 8'd0 : 8'd255;
        default:       off = OFF_W'($urandom_range(255));
      endcase
      // upper data bits are don't-care for the offset registers
      write_reg(CFG_IDX_W'(CFG_SWING_FIRST + i), {10'($urandom_range(1023)), off});
    end
    write_reg(CFG_UNUSED, 18'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_word(output in_t w);
    if ($urandom_range(99) < 10) begin
      w = IN_W'($urandom);
    end else begin
      if ($urandom_range(99) < 10)
        cur_tempo = 8'(($urandom_range(99) < 80) ? $urandom_range(200, 30)
                                                 : $urandom_range(255));
      lvl_rst = lvl_rst ? ($urandom_range(99) >= 40) : ($urandom_range(99) < 3);
      lvl_btn = lvl_btn ? ($urandom_range(99) >= 40) : ($urandom_range(99) < 4);
      lvl_cv  = lvl_cv  ? ($urandom_range(99) >= 40) : ($urandom_range(99) < 5);
      if ($urandom_range(99) < 2) lvl_cvp = !lvl_cvp;
      w = mk_word(cur_tempo, 8'($urandom_range(255)), 1'($urandom_range(1)), lvl_rst,
                  lvl_cvp, lvl_cv, lvl_btn);
    end
  endtask

  task automatic random_run(input int n);
    in_t w;
    for (int i = 0; i < n; i++) begin
      random_word(w);
      send_word(w);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset-value configuration, field extremes and run/reset edge cases
    send_word(mk_word(8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd29,  8'd25,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd30,  8'd26,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd200, 8'd154, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd201, 8'd155, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(mk_word(8'd120, 8'd128, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(mk_word(8'd120, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

    load_setting(18'd0, OFFS_EDGE);
    random_run(60);
    load_setting(18'($urandom_range(64, 16)), OFFS_RANDOM);
    quiet <= 1'b1;
    random_run(200);
    quiet <= 1'b0;
    load_setting(18'($urandom_range(300, 16)), OFFS_EDGE_INV);
    random_run(150);
    load_setting(18'($urandom_range(15, 1)), OFFS_RANDOM);
    random_run(150);
    load_setting(18'd8000, OFFS_RANDOM);
    random_run(40);
    load_setting(18'd192000, OFFS_RANDOM);
    random_run(40);
    load_setting(18'h3FFFF, OFFS_RANDOM);
    random_run(30);
    for (int s = 0; s < 3; s++) begin
      load_setting(18'($urandom_range(400, 8)), OFFS_RANDOM);
      random_run(150);
    end

    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words checked over %0d register settings (zero to full-scale rates)",
             words_sent, settings_used);
    $display("covered tempo/width clamps, run and reset edges, unplugged run CV, stalls");
    if (mismatches == 0 && outstanding == 0) begin
      $display("** tempo_clock_divider_with_swing_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words never returned", mismatches, outstanding);
      $display("** tempo_clock_divider_with_swing_unit: FAILED **");
    end
    $finish;
  end

endmodule
